>>> rtl/cooling_unit_mode_controller_macros.svh
// assertion macros for the cooling unit mode controller
// expects clk and rst_n in the scope of the module that uses them
`ifndef COOLING_UNIT_MODE_CONTROLLER_MACROS_SVH
`define COOLING_UNIT_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CUMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cooling unit controller check failed");

// next-cycle implication, checked out of reset
`define CUMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cooling unit controller check failed");

`endif

>>> rtl/cumc_pkg.sv
// shared types and constants for the cooling unit mode controller
// no dependencies
package cumc_pkg;

  // port widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int RAW_W       = 10;
  localparam int TEMP_W      = 16;
  localparam int TIME_W      = 32;

  // operating mode
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_COOLING = 2'd2,
    MODE_UNFROST = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TEMP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STANDBY_BAND  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFF_BAND      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNFROST_START = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNFROST_STOP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_MIN_MS   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_FAIL_MS  = 3'd6;

  // register reset values
  localparam logic [14:0]        RST_TARGET_TEMP   = 15'd7168;
  localparam logic [11:0]        RST_STANDBY_BAND  = 12'd256;
  localparam logic [11:0]        RST_OFF_BAND      = 12'd768;
  localparam logic signed [15:0] RST_UNFROST_START = 16'sd1280;
  localparam logic signed [15:0] RST_UNFROST_STOP  = 16'sd2560;
  localparam logic [31:0]        RST_PUMP_MIN_MS   = 32'd15000;
  localparam logic [31:0]        RST_PUMP_FAIL_MS  = 32'd60000;

  // fan speed codes
  localparam logic [1:0] IN_FAN_OFF   = 2'd0;
  localparam logic [1:0] IN_FAN_LOW   = 2'd1;
  localparam logic [1:0] IN_FAN_HIGH  = 2'd3;
  localparam logic [1:0] OUT_FAN_OFF  = 2'd0;
  localparam logic [1:0] OUT_FAN_HIGH = 2'd2;

  // air map: floor((raw-517)*416/25)+6656, biased by 525 counts so the
  // quotient stays positive; 16u + floor(16u/25) - 2080
  localparam logic [10:0] AIR_BIAS   = 11'd8;
  localparam logic [14:0] AIR_RECIP  = 15'd20972;
  localparam int          AIR_SHIFT  = 19;
  localparam logic [16:0] AIR_OFFSET = 17'd2080;

  // cooler map: floor((raw-515)*1664/101)+6656, biased by 606 counts;
  // 16u + floor(48u/101) - 3328
  localparam logic [10:0] COOL_BIAS   = 11'd91;
  localparam logic [13:0] COOL_RECIP  = 14'd10382;
  localparam int          COOL_SHIFT  = 20;
  localparam logic [16:0] COOL_OFFSET = 17'd3328;

  // hysteresis margin for leaving off
  localparam logic signed [17:0] OFF_EXIT_MARGIN = 18'sd128;

  // linearized temperatures, Q8.8 degrees
  typedef struct packed {
    logic signed [TEMP_W-1:0] air;
    logic signed [TEMP_W-1:0] cooler;
  } temps_t;

endpackage

>>> rtl/cumc_linearize.sv
// thermistor linearization to signed Q8.8 degrees, floored
// uses cumc_pkg
module cumc_linearize (
  input  logic [cumc_pkg::RAW_W-1:0] air_raw,
  input  logic [cumc_pkg::RAW_W-1:0] cooler_raw,
  output cumc_pkg::temps_t           temps
);

  logic [10:0] air_u;
  logic [14:0] air_x;
  logic [29:0] air_prod;
  logic [14:0] air_q;
  logic [16:0] air_s;
  logic [10:0] cool_u;
  logic [15:0] cool_x;
  logic [29:0] cool_prod;
  logic [14:0] cool_q;
  logic [16:0] cool_s;

  // air: biased reading times 16, remainder part by reciprocal of 25
  assign air_u    = {1'b0, air_raw} + cumc_pkg::AIR_BIAS;
  assign air_x    = {air_u, 4'b0000};
  assign air_prod = 30'(air_x) * 30'(cumc_pkg::AIR_RECIP);
  assign air_q    = air_x + 15'(air_prod >> cumc_pkg::AIR_SHIFT);
  assign air_s    = {2'b00, air_q} - cumc_pkg::AIR_OFFSET;

  // cooler: 48u by reciprocal of 101, plus 16u
  assign cool_u    = {1'b0, cooler_raw} + cumc_pkg::COOL_BIAS;
  assign cool_x    = {cool_u, 5'b00000} + {1'b0, cool_u, 4'b0000};
  assign cool_prod = 30'(cool_x) * 30'(cumc_pkg::COOL_RECIP);
  assign cool_q    = {cool_u, 4'b0000} + 15'(cool_prod >> cumc_pkg::COOL_SHIFT);
  assign cool_s    = {2'b00, cool_q} - cumc_pkg::COOL_OFFSET;

  assign temps.air    = $signed(air_s[15:0]);
  assign temps.cooler = $signed(cool_s[15:0]);

endmodule

>>> rtl/cooling_unit_mode_controller.sv
// cooling unit mode controller top level: temperature stage, mode and pump
// control, result register; uses cumc_pkg, cumc_linearize and the macros header
//
// One request on the in_ channel is one control tick: two thermistor readings,
// the two float contacts and a millisecond timestamp. Each tick gives exactly
// one result on the out_ channel: mode, fan speeds, compressor and pump drives
// and the tank flags. Requests are taken one per clock while in_tready is high;
// the edge that takes a request loads the linearized temperatures into the
// temperature stage, and a later edge, once the result register is free, runs
// the mode and pump update into the result register. The rate is set by the
// mode, pump and timestamp registers, updated once per tick by that update.
// When the receiver holds out_tready low, the result stays put, one more tick
// is held in the temperature stage, and then in_tready drops until the result
// is taken. Registers are written on cfg_ with cfg_wr_en, one per clock; the
// user must write them only while no tick is in flight; the block does not
// enforce it. Reset (rst_n low at a clock edge) restores the register defaults,
// sets mode and pump to off, the pump timestamp to zero, empties both stages.
module cooling_unit_mode_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: air_raw[9:0], cooler_raw[19:10], contact_no_low[20],
  // contact_nc_low[21], now_ms[53:22], zero fill[55:54]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cumc_pkg::IN_TDATA_W-1:0] in_tdata,
  // out_tdata: mode[1:0], indoor_fan[3:2], outdoor_fan[5:4], compressor_on[6],
  // pump_on[7], water_full[8], water_error[9], zero fill[15:10]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cumc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [cumc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cumc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "cooling_unit_mode_controller_macros.svh"

  // configuration registers
  logic [14:0]        target_r;
  logic [11:0]        standby_band_r;
  logic [11:0]        off_band_r;
  logic signed [15:0] unfrost_start_r;
  logic signed [15:0] unfrost_stop_r;
  logic [31:0]        pump_min_r;
  logic [31:0]        pump_fail_r;

  // temperature stage
  cumc_pkg::temps_t                  temps;
  cumc_pkg::temps_t                  s1_temps_r;
  logic                              s1_no_r;
  logic                              s1_nc_r;
  logic [cumc_pkg::TIME_W-1:0]       s1_now_r;
  logic                              s1_valid_r;

  // control state
  cumc_pkg::mode_t                   mode_r;
  cumc_pkg::mode_t                   mode_nxt;
  cumc_pkg::mode_t                   mode_temp;
  logic                              pump_r;
  logic                              pump_nxt;
  logic [cumc_pkg::TIME_W-1:0]       stamp_r;
  logic [cumc_pkg::TIME_W-1:0]       stamp_nxt;

  // result register
  logic                              out_valid_r;
  cumc_pkg::mode_t                   out_mode_r;
  logic [1:0]                        out_infan_r;
  logic [1:0]                        out_outfan_r;
  logic                              out_comp_r;
  logic                              out_pump_r;
  logic                              out_full_r;
  logic                              out_err_r;
  logic [1:0]                        infan_nxt;
  logic [1:0]                        outfan_nxt;
  logic                              comp_nxt;

  // update terms
  logic                              out_free;
  logic                              s2_load;
  logic                              in_acc;
  logic                              water_err;
  logic                              water_full;
  logic signed [17:0]                delta;
  logic signed [17:0]                neg_sb;
  logic signed [17:0]                neg_ob;
  logic                              below_sb;
  logic                              below_ob;
  logic                              above_off_exit;
  logic [cumc_pkg::TIME_W-1:0]       elapsed;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s2_load   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r        <= cumc_pkg::RST_TARGET_TEMP;
      standby_band_r  <= cumc_pkg::RST_STANDBY_BAND;
      off_band_r      <= cumc_pkg::RST_OFF_BAND;
      unfrost_start_r <= cumc_pkg::RST_UNFROST_START;
      unfrost_stop_r  <= cumc_pkg::RST_UNFROST_STOP;
      pump_min_r      <= cumc_pkg::RST_PUMP_MIN_MS;
      pump_fail_r     <= cumc_pkg::RST_PUMP_FAIL_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cumc_pkg::CFG_TARGET_TEMP:   target_r        <= cfg_wdata[14:0];
        cumc_pkg::CFG_STANDBY_BAND:  standby_band_r  <= cfg_wdata[11:0];
        cumc_pkg::CFG_OFF_BAND:      off_band_r      <= cfg_wdata[11:0];
        cumc_pkg::CFG_UNFROST_START: unfrost_start_r <= $signed(cfg_wdata[15:0]);
        cumc_pkg::CFG_UNFROST_STOP:  unfrost_stop_r  <= $signed(cfg_wdata[15:0]);
        cumc_pkg::CFG_PUMP_MIN_MS:   pump_min_r      <= cfg_wdata;
        cumc_pkg::CFG_PUMP_FAIL_MS:  pump_fail_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // linearize straight from the request
  cumc_linearize u_lin (
    .air_raw    (in_tdata[9:0]),
    .cooler_raw (in_tdata[19:10]),
    .temps      (temps)
  );

  // temperature stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_temps_r <= temps;
      s1_no_r    <= in_tdata[20];
      s1_nc_r    <= in_tdata[21];
      s1_now_r   <= in_tdata[53:22];
    end
  end

  // tank flags and temperature comparisons
  assign water_err      = s1_no_r ^ s1_nc_r;
  assign water_full     = !water_err && s1_no_r;
  assign delta          = $signed({{2{s1_temps_r.air[15]}}, s1_temps_r.air})
                          - $signed({3'b000, target_r});
  assign neg_sb         = 18'sd0 - $signed({6'b000000, standby_band_r});
  assign neg_ob         = 18'sd0 - $signed({6'b000000, off_band_r});
  assign below_sb       = delta < neg_sb;
  assign below_ob       = delta < neg_ob;
  assign above_off_exit = delta > (neg_ob + cumc_pkg::OFF_EXIT_MARGIN);
  assign elapsed        = s1_now_r - stamp_r;

  // mode, pump and drive update
  always_comb begin
    mode_nxt  = mode_r;
    mode_temp = mode_r;
    pump_nxt  = pump_r;
    case (mode_r)
      cumc_pkg::MODE_UNFROST, cumc_pkg::MODE_COOLING: begin
        // unfrosting may leave first, then the cooling checks still apply
        if (mode_r == cumc_pkg::MODE_UNFROST && s1_temps_r.cooler > unfrost_stop_r) begin
          mode_temp = below_sb ? cumc_pkg::MODE_STANDBY : cumc_pkg::MODE_COOLING;
        end
        if (below_sb) begin
          mode_nxt = cumc_pkg::MODE_STANDBY;
        end else if (s1_temps_r.cooler < unfrost_start_r) begin
          mode_nxt = cumc_pkg::MODE_UNFROST;
        end else begin
          mode_nxt = mode_temp;
        end
      end
      cumc_pkg::MODE_STANDBY: begin
        if (delta > 18'sd0) begin
          mode_nxt = cumc_pkg::MODE_COOLING;
        end else if (below_ob) begin
          mode_nxt = cumc_pkg::MODE_OFF;
        end
      end
      default: begin
        if (above_off_exit) begin
          mode_nxt = cumc_pkg::MODE_STANDBY;
        end
      end
    endcase

    // pump runs while full, for a minimum time, and trips the unit if stuck
    if (pump_r) begin
      if (!water_full && elapsed > pump_min_r) begin
        pump_nxt = 1'b0;
      end else if (elapsed > pump_fail_r) begin
        mode_nxt = cumc_pkg::MODE_OFF;
      end
    end else if (water_full) begin
      pump_nxt = 1'b1;
    end
    if (water_err) begin
      mode_nxt = cumc_pkg::MODE_OFF;
    end

    stamp_nxt = pump_nxt ? stamp_r : s1_now_r;

    case (mode_nxt)
      cumc_pkg::MODE_UNFROST: begin
        infan_nxt  = cumc_pkg::IN_FAN_HIGH;
        outfan_nxt = cumc_pkg::OUT_FAN_OFF;
        comp_nxt   = 1'b0;
      end
      cumc_pkg::MODE_COOLING: begin
        infan_nxt  = cumc_pkg::IN_FAN_HIGH;
        outfan_nxt = cumc_pkg::OUT_FAN_HIGH;
        comp_nxt   = 1'b1;
      end
      cumc_pkg::MODE_STANDBY: begin
        infan_nxt  = cumc_pkg::IN_FAN_LOW;
        outfan_nxt = cumc_pkg::OUT_FAN_OFF;
        comp_nxt   = 1'b0;
      end
      default: begin
        infan_nxt  = cumc_pkg::IN_FAN_OFF;
        outfan_nxt = cumc_pkg::OUT_FAN_OFF;
        comp_nxt   = 1'b0;
      end
    endcase
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cumc_pkg::MODE_OFF;
      pump_r  <= 1'b0;
      stamp_r <= '0;
    end else if (s2_load) begin
      mode_r  <= mode_nxt;
      pump_r  <= pump_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_mode_r   <= mode_nxt;
      out_infan_r  <= infan_nxt;
      out_outfan_r <= outfan_nxt;
      out_comp_r   <= comp_nxt;
      out_pump_r   <= pump_nxt;
      out_full_r   <= water_full;
      out_err_r    <= water_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_err_r, out_full_r, out_pump_r, out_comp_r,
                       out_outfan_r, out_infan_r, out_mode_r};

  // checks
  `CUMC_ASSERT_IMP(a_err_forces_off, out_valid_r && out_err_r,
                   out_mode_r == cumc_pkg::MODE_OFF && !out_full_r)
  `CUMC_ASSERT_IMP(a_comp_only_cooling, out_valid_r,
                   out_comp_r == (out_mode_r == cumc_pkg::MODE_COOLING))
  `CUMC_ASSERT_NEXT(a_stamp_tracks_idle_pump, s2_load && !pump_nxt,
                    stamp_r == $past(s1_now_r))
  `CUMC_ASSERT_IMP(a_ready_when_drained, !out_valid_r, in_tready)

endmodule

>>> tb/tb.sv
// self-checking bench for the cooling unit mode controller: directed ticks,
// then random tank, temperature and timer sequences under several settings
// depends on cumc_pkg and the cooling_unit_mode_controller top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 17;
  localparam int AIR_ZERO       = 517;
  localparam int AIR_SPAN       = 200;
  localparam int COOL_ZERO      = 515;
  localparam int COOL_SPAN      = 202;
  localparam int MAP_GAIN       = 3328;
  localparam int Q88_26C        = 6656;

  // one result, packed as on out_tdata
  typedef struct packed {
    logic       water_error;
    logic       water_full;
    logic       pump_on;
    logic       compressor_on;
    logic [1:0] outdoor_fan;
    logic [1:0] indoor_fan;
    logic [1:0] mode;
  } tick_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  // in_tdata: air_raw, cooler_raw, contact_no_low, contact_nc_low, now_ms, zero fill
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [cumc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  // out_tdata: mode, indoor_fan, outdoor_fan, compressor_on, pump_on,
  // water_full, water_error, zero fill
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [cumc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en  = 1'b0;
  logic [cumc_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [cumc_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;

  cooling_unit_mode_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // controller copy: registers and state
  logic [14:0]        set_target        = cumc_pkg::RST_TARGET_TEMP;
  logic [11:0]        set_standby_band  = cumc_pkg::RST_STANDBY_BAND;
  logic [11:0]        set_off_band      = cumc_pkg::RST_OFF_BAND;
  logic signed [15:0] set_unfrost_start = cumc_pkg::RST_UNFROST_START;
  logic signed [15:0] set_unfrost_stop  = cumc_pkg::RST_UNFROST_STOP;
  logic [31:0]        set_pump_min      = cumc_pkg::RST_PUMP_MIN_MS;
  logic [31:0]        set_pump_fail     = cumc_pkg::RST_PUMP_FAIL_MS;
  cumc_pkg::mode_t    cur_mode          = cumc_pkg::MODE_OFF;
  logic               pump_running      = 1'b0;
  logic [31:0]        pump_idle_stamp   = '0;

  tick_result_t pending_results[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           no_gaps = 1'b0;

  // random walk state for the stimulus
  int          air_pos = 548;
  int          cool_pos = 266;
  int          air_mid = 548;
  int          cool_mid_lo = 189;
  int          cool_mid_hi = 266;
  logic        tank_full = 1'b0;
  logic [31:0] clock_ms = '0;

  // converter reading to Q8.8 degrees, floored
  function automatic int q88_of_raw(input logic [9:0] raw, input int zero_cnt, input int span);
    int num, quot;
    num  = (int'(raw) - zero_cnt) * MAP_GAIN;
    quot = num / span;
    if ((num % span) != 0 && num < 0) quot = quot - 1;
    return quot + Q88_26C;
  endfunction

  // rough inverse, to center the walks on a threshold
  function automatic int raw_near_q88(input int q, input int zero_cnt, input int span);
    int r;
    r = zero_cnt + ((q - Q88_26C) * span) / MAP_GAIN;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    return r;
  endfunction

  function automatic int walk(input int pos, input int mid, input int stride);
    int p;
    case ($urandom_range(0, 19))
      0, 1: p = int'($urandom_range(0, 1023));
      2: p = mid;
      default: p = pos + int'($urandom_range(0, 2 * stride)) - stride;
    endcase
    if (p < 0) p = 0;
    if (p > 1023) p = 1023;
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // one control tick: mode, pump and drives, updating the copied state
  function automatic tick_result_t predict_tick(input logic [9:0] air_raw,
      input logic [9:0] cool_raw, input logic no_full, input logic nc_full,
      input logic [31:0] now);
    tick_result_t    r;
    int              air_q, cool_q, delta, sb_lim, off_lim;
    logic            err, full;
    logic [31:0]     elapsed;
    cumc_pkg::mode_t m;
    air_q   = q88_of_raw(air_raw, AIR_ZERO, AIR_SPAN);
    cool_q  = q88_of_raw(cool_raw, COOL_ZERO, COOL_SPAN);
    err     = no_full ^ nc_full;
    full    = err ? 1'b0 : no_full;
    delta   = air_q - int'(set_target);
    sb_lim  = -int'(set_standby_band);
    off_lim = -int'(set_off_band);
    m       = cur_mode;

    // mode hysteresis
    case (m)
      cumc_pkg::MODE_UNFROST, cumc_pkg::MODE_COOLING: begin
        // unfrosting ends when the coil warms, then the cooling checks still run
        if (m == cumc_pkg::MODE_UNFROST && cool_q > int'(set_unfrost_stop))
          m = (delta < sb_lim) ? cumc_pkg::MODE_STANDBY : cumc_pkg::MODE_COOLING;
        if (delta < sb_lim) m = cumc_pkg::MODE_STANDBY;
        else if (cool_q < int'(set_unfrost_start)) m = cumc_pkg::MODE_UNFROST;
      end
      cumc_pkg::MODE_STANDBY: begin
        if (delta > 0) m = cumc_pkg::MODE_COOLING;
        else if (delta < off_lim) m = cumc_pkg::MODE_OFF;
      end
      default: begin
        if (delta > off_lim + int'(cumc_pkg::OFF_EXIT_MARGIN)) m = cumc_pkg::MODE_STANDBY;
      end
    endcase

    // pump run time against the last tick it was off
    if (pump_running) begin
      elapsed = now - pump_idle_stamp;
      if (!full && elapsed > set_pump_min) pump_running = 1'b0;
      else if (elapsed > set_pump_fail) m = cumc_pkg::MODE_OFF;
    end else if (full) begin
      pump_running = 1'b1;
    end
    if (err) m = cumc_pkg::MODE_OFF;
    cur_mode = m;

    // drives
    r = '0;
    r.mode = m;
    case (m)
      cumc_pkg::MODE_UNFROST: begin
        r.indoor_fan  = cumc_pkg::IN_FAN_HIGH;
        r.outdoor_fan = cumc_pkg::OUT_FAN_OFF;
      end
      cumc_pkg::MODE_COOLING: begin
        r.indoor_fan    = cumc_pkg::IN_FAN_HIGH;
        r.outdoor_fan   = cumc_pkg::OUT_FAN_HIGH;
        r.compressor_on = 1'b1;
      end
      cumc_pkg::MODE_STANDBY: begin
        r.indoor_fan  = cumc_pkg::IN_FAN_LOW;
        r.outdoor_fan = cumc_pkg::OUT_FAN_OFF;
      end
      default: begin
        r.indoor_fan  = cumc_pkg::IN_FAN_OFF;
        r.outdoor_fan = cumc_pkg::OUT_FAN_OFF;
      end
    endcase
    if (!pump_running) pump_idle_stamp = now;
    r.pump_on     = pump_running;
    r.water_full  = full;
    r.water_error = err;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("tb: mismatch on %s, expected %0d, got %0d", name, want, got);
    end
  endtask

  // sample handshakes on the falling edge before the edge that takes them
  always @(negedge clk) begin : tick_monitor
    tick_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_tick(in_tdata[9:0], in_tdata[19:10],
                                               in_tdata[20], in_tdata[21], in_tdata[53:22]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[9:0];
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("tb: result %h with no request pending", got);
        end else begin
          want = pending_results.pop_front();
          compare_field("mode", want.mode, got.mode);
          compare_field("indoor_fan", want.indoor_fan, got.indoor_fan);
          compare_field("outdoor_fan", want.outdoor_fan, got.outdoor_fan);
          compare_field("compressor_on", want.compressor_on, got.compressor_on);
          compare_field("pump_on", want.pump_on, got.pump_on);
          compare_field("water_full", want.water_full, got.water_full);
          compare_field("water_error", want.water_error, got.water_error);
        end
      end
      // watchdog on cycles with no handshake
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin : result_sink
    int unsigned hold;
    logic        taken;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_tvalid;
        @(posedge clk);
      end while (!taken);
    end
  end

  // one request; returns on the edge that takes it, tvalid still high
  task automatic send_tick(input logic [9:0] air_raw, input logic [9:0] cool_raw,
      input logic no_full, input logic nc_full, input logic [31:0] now);
    int unsigned gap;
    logic        taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, now, nc_full, no_full, cool_raw, air_raw};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // stop sending and wait for every result, plus the pipeline depth
  task automatic drain_ticks();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cumc_pkg::CFG_INDEX_W-1:0] idx,
      input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      cumc_pkg::CFG_TARGET_TEMP:   set_target        = value[14:0];
      cumc_pkg::CFG_STANDBY_BAND:  set_standby_band  = value[11:0];
      cumc_pkg::CFG_OFF_BAND:      set_off_band      = value[11:0];
      cumc_pkg::CFG_UNFROST_START: set_unfrost_start = value[15:0];
      cumc_pkg::CFG_UNFROST_STOP:  set_unfrost_stop  = value[15:0];
      cumc_pkg::CFG_PUMP_MIN_MS:   set_pump_min      = value;
      cumc_pkg::CFG_PUMP_FAIL_MS:  set_pump_fail     = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // all registers, written while idle; walks recentered on the new thresholds
  task automatic apply_settings(input logic [31:0] target, input logic [31:0] sb_band,
      input logic [31:0] ob_band, input logic [31:0] uf_start, input logic [31:0] uf_stop,
      input logic [31:0] pmin, input logic [31:0] pfail);
    drain_ticks();
    write_reg(cumc_pkg::CFG_TARGET_TEMP, target);
    write_reg(cumc_pkg::CFG_STANDBY_BAND, sb_band);
    write_reg(cumc_pkg::CFG_OFF_BAND, ob_band);
    write_reg(cumc_pkg::CFG_UNFROST_START, uf_start);
    write_reg(cumc_pkg::CFG_UNFROST_STOP, uf_stop);
    write_reg(cumc_pkg::CFG_PUMP_MIN_MS, pmin);
    write_reg(cumc_pkg::CFG_PUMP_FAIL_MS, pfail);
    air_mid     = raw_near_q88(int'(set_target), AIR_ZERO, AIR_SPAN);
    cool_mid_lo = raw_near_q88(int'(set_unfrost_start), COOL_ZERO, COOL_SPAN);
    cool_mid_hi = raw_near_q88(int'(set_unfrost_stop), COOL_ZERO, COOL_SPAN);
    air_pos     = air_mid;
    cool_pos    = cool_mid_hi;
  endtask

  // tank cycles and temperatures near the thresholds, with noise mixed in
  task automatic run_random(input int n_ticks, input int unsigned step_max);
    logic no_full, nc_full;
    for (int i = 0; i < n_ticks; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      // sender holds off until everything is back
      if (i == n_ticks / 2) drain_ticks();
      air_pos  = walk(air_pos, air_mid, 12);
      cool_pos = walk(cool_pos, $urandom_range(0, 1) ? cool_mid_lo : cool_mid_hi, 10);
      if ($urandom_range(0, 11) == 0) tank_full = ~tank_full;
      if ($urandom_range(0, 29) == 0) begin
        no_full = $urandom_range(0, 1);
        nc_full = ~no_full;
      end else begin
        no_full = tank_full;
        nc_full = tank_full;
      end
      if ($urandom_range(0, 59) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      send_tick(air_pos[9:0], cool_pos[9:0], no_full, nc_full, clock_ms);
    end
    no_gaps = 1'b0;
  endtask

  // reset settings: every mode move, pump timing edges, contact faults, time wrap
  task automatic test_directed_defaults();
    send_tick(10'd0, 10'd0, 1'b0, 1'b0, 32'd0);
    send_tick(10'd1023, 10'd1023, 1'b0, 1'b0, 32'd100);
    send_tick(10'd560, 10'd400, 1'b0, 1'b0, 32'd200);
    send_tick(10'd560, 10'd100, 1'b0, 1'b0, 32'd300);
    send_tick(10'd560, 10'd230, 1'b0, 1'b0, 32'd400);
    send_tick(10'd560, 10'd400, 1'b0, 1'b0, 32'd500);
    send_tick(10'd560, 10'd100, 1'b0, 1'b0, 32'd600);
    send_tick(10'd500, 10'd400, 1'b0, 1'b0, 32'd700);
    send_tick(10'd400, 10'd400, 1'b0, 1'b0, 32'd800);
    send_tick(10'd548, 10'd400, 1'b0, 1'b0, 32'd900);
    send_tick(10'd548, 10'd400, 1'b1, 1'b1, 32'd1000);
    send_tick(10'd548, 10'd400, 1'b0, 1'b0, 32'd2000);
    send_tick(10'd548, 10'd400, 1'b0, 1'b0, 32'd15900);
    send_tick(10'd548, 10'd400, 1'b0, 1'b0, 32'd15901);
    send_tick(10'd560, 10'd400, 1'b1, 1'b1, 32'd16000);
    send_tick(10'd560, 10'd400, 1'b1, 1'b1, 32'd76000);
    send_tick(10'd560, 10'd400, 1'b1, 1'b0, 32'd76100);
    send_tick(10'd560, 10'd400, 1'b0, 1'b1, 32'd76200);
    send_tick(10'd560, 10'd400, 1'b0, 1'b0, 32'hFFFF_FF00);
    send_tick(10'd560, 10'd400, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_tick(10'd560, 10'd400, 1'b0, 1'b0, 32'h0000_1000);
    send_tick(10'd560, 10'd400, 1'b0, 1'b0, 32'h0001_0000);
    send_tick(10'd0, 10'd1023, 1'b1, 1'b1, 32'h8000_0000);
    send_tick(10'd1023, 10'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_short_pump_timers();
    apply_settings(cumc_pkg::RST_TARGET_TEMP, cumc_pkg::RST_STANDBY_BAND,
                   cumc_pkg::RST_OFF_BAND, cumc_pkg::RST_UNFROST_START,
                   cumc_pkg::RST_UNFROST_STOP, 32'd400, 32'd2500);
    run_random(250, 150);
  endtask

  task automatic test_register_low_extremes();
    apply_settings(32'd0, 32'd0, 32'd0, -32'sd2560, -32'sd2560, 32'd0, 32'd0);
    run_random(150, 50);
  endtask

  task automatic test_register_high_extremes();
    apply_settings(32'd16384, 32'd2560, 32'd2560, 32'd16384, 32'd16384,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(150, 1 << 20);
  endtask

  task automatic test_random_settings();
    logic [31:0] pmin, pfail;
    repeat (6) begin
      pmin  = $urandom_range(0, 6000);
      pfail = $urandom_range(0, 30000);
      apply_settings($urandom_range(0, 16384), $urandom_range(0, 2560),
                     $urandom_range(0, 2560), $urandom_range(0, 18944) - 2560,
                     $urandom_range(0, 18944) - 2560, pmin, pfail);
      run_random(150, 1 + (pmin + pfail) / 10);
    end
  endtask

  task automatic test_time_wrap();
    apply_settings(cumc_pkg::RST_TARGET_TEMP, cumc_pkg::RST_STANDBY_BAND,
                   cumc_pkg::RST_OFF_BAND, cumc_pkg::RST_UNFROST_START,
                   cumc_pkg::RST_UNFROST_STOP, 32'd1000, 32'd8000);
    clock_ms = 32'hFFFF_E000;
    run_random(150, 400);
  endtask

  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_short_pump_timers();
    test_register_low_extremes();
    test_register_high_extremes();
    test_random_settings();
    test_time_wrap();
    drain_ticks();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/cumc_pkg.sv
rtl/cumc_linearize.sv
rtl/cooling_unit_mode_controller.sv
tb/tb.sv
